// ===== src/rbgs_pkg.sv =====
// Shared types and codes for the red-black Gauss-Seidel Poisson solver.
// No dependencies.
`default_nettype none
package rbgs_pkg;
  localparam logic [1:0] REG_GRID_SIZE  = 2'd0;
  localparam logic [1:0] REG_TOLERANCE  = 2'd1;
  localparam logic [1:0] REG_STEP_SQ    = 2'd2;
  localparam logic [1:0] REG_ITER_LIMIT = 2'd3;

  localparam logic MODE_RUN  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [30:0] CHANGE_MAX = 31'h7FFF_FFFF;

  typedef logic [30:0] change_t;
  typedef logic [15:0] count_t;
endpackage
`default_nettype wire

// ===== src/rbgs_if.sv =====
// Handshake channels of the solver: command, result and register write.
// Depends on rbgs_pkg.
`default_nettype none
interface rbgs_cmd_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [5:0] row;
  logic [5:0] col;
  modport source (output valid, mode, row, col, input ready);
  modport sink   (input valid, mode, row, col, output ready);
endinterface

interface rbgs_rsp_if import rbgs_pkg::*;;
  logic        valid;
  logic        ready;
  logic [31:0] cell_value;
  count_t      sweeps_done;
  change_t     final_change;
  logic        converged;
  modport source (output valid, cell_value, sweeps_done, final_change, converged,
                  input ready);
  modport sink   (input valid, cell_value, sweeps_done, final_change, converged,
                  output ready);
endinterface

interface rbgs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [30:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/rbgs_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`default_nettype none
module rbgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire                               clk,
  input  wire                               we,
  input  wire  [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire  [WIDTH-1:0]                  wdata,
  input  wire  [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/red_black_gauss_seidel_poisson.sv =====
// Red-black Gauss-Seidel Poisson solver, top level.
// Depends on rbgs_pkg, rbgs_if (cmd, rsp, cfg channels) and rbgs_ram.
//
// Usage:
//   cfg: register writes (grid_size, tolerance, step_squared, iteration_limit),
//        always ready; write only while the block is idle.
//   cmd: mode 0 starts a run (clear grid, sweep until converged or limit),
//        mode 1 reads cell (row, col). Accepted only in the idle state.
//   rsp: one item per command with the cell value (zero for a run) and the
//        statistics of the last run.
// Sequence (n = effective grid size, G = GRID_MAX):
//   read: the command is accepted in idle, a read-wait state, then the done state issues the result item.
//   run:  the whole G*G grid is cleared, then each of the n*n cells takes a setup step,
//         reads on the single read port for the cell and its four neighbors,
//         compute and write back, with row and color turns in each sweep,
//         and the done state issues the result item after the last sweep.
// Reset restores the register defaults and clears the statistics; reads
// return zero until the first run has cleared the grid memory. A stalled
// receiver holds the result register; one more command is accepted and its
// result waits in the done state until the register frees up.
`default_nettype none
module red_black_gauss_seidel_poisson import rbgs_pkg::*; #(
  parameter int GRID_MAX   = 64,
  parameter int VALUE_BITS = 32
) (
  input wire          clk,
  input wire          rst,
  rbgs_cfg_if.sink    cfg,
  rbgs_cmd_if.sink    cmd,
  rbgs_rsp_if.source  rsp
);
  localparam int DEPTH = GRID_MAX * GRID_MAX;
  localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);
  localparam int PW    = $clog2(GRID_MAX + 1) + 1;
  localparam int SW    = (VALUE_BITS > 26 ? VALUE_BITS : 26) + 3;
  localparam int DW    = (VALUE_BITS + 2 > 32 ? VALUE_BITS + 2 : 32);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_CALC  = 4'd4;
  localparam logic [3:0] S_WR    = 4'd5;
  localparam logic [3:0] S_SWEEP = 4'd6;
  localparam logic [3:0] S_RDW   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [6:0]  grid_size;
  change_t     tolerance;
  logic [24:0] step_squared;
  count_t      iteration_limit;

  logic [3:0]  state;
  logic [2:0]  k;
  logic [PW-1:0] r, c;
  logic        color;
  change_t     big;
  logic signed [VALUE_BITS-1:0] nb [4];
  logic signed [VALUE_BITS-1:0] oldv, newv;
  logic [3:0]  nb_ok;
  logic        rd_hit;
  logic        ran;
  logic [31:0] cellv;
  count_t      sweep_count;
  change_t     largest_change;
  logic        met_tolerance;

  logic [PW-1:0] n_eff;
  count_t        limit_eff;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [VALUE_BITS-1:0] wdata, rdata;

  function automatic logic [AW-1:0] addr_of(input int rr, input int cc);
    int a;
    begin
      a = rr * GRID_MAX + cc;
      return a[AW-1:0];
    end
  endfunction

  always_comb begin
    if (grid_size == 7'd0) begin
      n_eff = PW'(1);
    end else if (32'(grid_size) > GRID_MAX) begin
      n_eff = PW'(GRID_MAX);
    end else begin
      n_eff = PW'(grid_size);
    end
    limit_eff = (iteration_limit == 16'd0) ? 16'd1 : iteration_limit;
  end

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size       <= 7'd64;
      tolerance       <= 31'd1678;
      step_squared    <= 25'd3971;
      iteration_limit <= 16'd65535;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GRID_SIZE:  grid_size       <= cfg.data[6:0];
        REG_TOLERANCE:  tolerance       <= cfg.data;
        REG_STEP_SQ:    step_squared    <= cfg.data[24:0];
        REG_ITER_LIMIT: iteration_limit <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  rbgs_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_grid (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // read address sequence: self, north, south, west, east
  always_comb begin
    raddr = addr_of(int'(r), int'(c));
    if (state == S_IDLE) begin
      raddr = addr_of(int'(cmd.row), int'(cmd.col));
    end else begin
      case (k)
        3'd1: raddr = addr_of(int'(r) - 1, int'(c));
        3'd2: raddr = addr_of(int'(r) + 1, int'(c));
        3'd3: raddr = addr_of(int'(r), int'(c) - 1);
        3'd4: raddr = addr_of(int'(r), int'(c) + 1);
        default: raddr = addr_of(int'(r), int'(c));
      endcase
    end
    we    = (state == S_CLR) || (state == S_WR);
    waddr = addr_of(int'(r), int'(c));
    wdata = (state == S_WR) ? newv : '0;
  end

  // update arithmetic
  logic signed [SW-1:0] sum, quo;
  logic signed [VALUE_BITS-1:0] clamped;
  logic signed [DW-1:0] diff;
  logic [DW-1:0] adiff;
  change_t dsat;
  always_comb begin
    sum = SW'(nb[0]) + SW'(nb[1]) + SW'(nb[2]) + SW'(nb[3])
        - $signed({{(SW-25){1'b0}}, step_squared});
    quo = sum >>> 2;
    if (quo > $signed(SW'({1'b0, {(VALUE_BITS-1){1'b1}}}))) begin
      clamped = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end else if (quo < $signed(SW'($signed({1'b1, {(VALUE_BITS-1){1'b0}}})))) begin
      clamped = {1'b1, {(VALUE_BITS-1){1'b0}}};
    end else begin
      clamped = quo[VALUE_BITS-1:0];
    end
    diff  = DW'(newv) - DW'(oldv);
    adiff = diff[DW-1] ? DW'(-diff) : DW'(diff);
    dsat  = (adiff > DW'(CHANGE_MAX)) ? CHANGE_MAX : adiff[30:0];
  end

  logic [PW-1:0] r1;
  assign r1 = r + PW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      k              <= '0;
      ran            <= 1'b0;
      sweep_count    <= '0;
      largest_change <= '0;
      met_tolerance  <= 1'b0;
      rsp.valid      <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            if (cmd.mode == MODE_READ) begin
              rd_hit <= ran && (PW'(cmd.row) < n_eff) && (PW'(cmd.col) < n_eff)
                        && (32'(cmd.row) < GRID_MAX) && (32'(cmd.col) < GRID_MAX);
              state  <= S_RDW;
            end else begin
              ran         <= 1'b1;
              sweep_count <= '0;
              r     <= '0;
              c     <= '0;
              cellv <= '0;
              state <= S_CLR;
            end
          end
        end
        S_RDW: begin
          cellv <= rd_hit ? 32'(64'($signed(rdata))) : 32'd0;
          state <= S_DONE;
        end
        S_CLR: begin
          if (c + PW'(1) >= PW'(GRID_MAX)) begin
            c <= '0;
            if (r1 >= PW'(GRID_MAX)) begin
              r     <= '0;
              color <= 1'b0;
              big   <= '0;
              state <= S_START;
            end else begin
              r <= r1;
            end
          end else begin
            c <= c + PW'(1);
          end
        end
        S_START: begin
          if (r >= n_eff) begin
            if (!color) begin
              color <= 1'b1;
              r     <= '0;
              c     <= PW'(1);
            end else begin
              state <= S_SWEEP;
            end
          end else if (c >= n_eff) begin
            r <= r1;
            c <= PW'(r1[0] ^ color);
          end else begin
            nb_ok <= {c + PW'(1) < n_eff, c != '0, r1 < n_eff, r != '0};
            k     <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          case (k)
            3'd1: oldv  <= rdata;
            3'd2: nb[0] <= nb_ok[0] ? rdata : '0;
            3'd3: nb[1] <= nb_ok[1] ? rdata : '0;
            3'd4: nb[2] <= nb_ok[2] ? rdata : '0;
            3'd5: nb[3] <= nb_ok[3] ? rdata : '0;
            default: ;
          endcase
          k <= k + 3'd1;
          if (k == 3'd5) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          newv  <= clamped;
          state <= S_WR;
        end
        S_WR: begin
          if (dsat > big) begin
            big <= dsat;
          end
          c     <= c + PW'(2);
          state <= S_START;
        end
        S_SWEEP: begin
          sweep_count    <= sweep_count + 16'd1;
          largest_change <= big;
          if (big <= tolerance) begin
            met_tolerance <= 1'b1;
            state         <= S_DONE;
          end else if (sweep_count + 16'd1 >= limit_eff) begin
            met_tolerance <= 1'b0;
            state         <= S_DONE;
          end else begin
            color <= 1'b0;
            r     <= '0;
            c     <= '0;
            big   <= '0;
            state <= S_START;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.cell_value   <= cellv;
            rsp.sweeps_done  <= sweep_count;
            rsp.final_change <= largest_change;
            rsp.converged    <= met_tolerance;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd.ready = (state == S_IDLE);

`ifndef SYNTHESIS
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_CLR || state == S_WR)) else $error("grid write outside clear/update");
  a_calc_to_wr: assert property (@(posedge clk) disable iff (rst)
    state == S_CALC |=> state == S_WR) else $error("update not written back");
  a_wr_in_grid: assert property (@(posedge clk) disable iff (rst)
    state == S_WR |-> (r < n_eff && c < n_eff)) else $error("update outside grid");
`endif
endmodule
`default_nettype wire

// ===== test/rbgs_tb_if.sv =====
// Testbench view of the solver channels: the bench reuses the RTL interface file.
// This file holds only a timescale and depends on no other file.
`timescale 1ns / 1ps

// ===== test/tb_red_black_gauss_seidel_poisson.sv =====
// Self-checking bench for red_black_gauss_seidel_poisson: a bit-exact Gauss-Seidel
// predictor queues the expected result items, and a monitor checks each returned item.
// Depends on rbgs_pkg, rbgs_if and the solver RTL.
`timescale 1ns / 1ps
module tb_red_black_gauss_seidel_poisson;
  import rbgs_pkg::*;

  localparam int GRID_MAX  = 64;
  localparam int CYCLE_CAP = 4000000;

  typedef struct packed {
    logic       mode;
    logic [5:0] row;
    logic [5:0] col;
  } cmd_item_t;

  typedef struct packed {
    logic [31:0] cell_val;
    count_t      sweeps;
    change_t     change;
    logic        conv;
  } rsp_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rbgs_cfg_if cfg();
  rbgs_cmd_if cmd();
  rbgs_rsp_if rsp();

  red_black_gauss_seidel_poisson dut (.clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .rsp(rsp));

  always #5 clk = ~clk;

  cmd_item_t pending_cmds[$];
  rsp_item_t expected_rsps[$];
  int        send_idle_pct = 10;
  int        recv_idle_pct = 10;
  int        errors = 0;
  int        stall_req = 0;
  int        stall_seen = 0;
  int        stall_left = 0;
  longint    cycles = 0;

  // solver state mirror
  longint      grid[GRID_MAX*GRID_MAX];
  int unsigned sweeps_m;
  longint      change_m;
  bit          conv_m;
  int unsigned n_reg;
  longint      tol_reg;
  longint      step_reg;
  int unsigned lim_reg;

  function automatic int unsigned eff_size();
    if (n_reg < 1) return 1;
    if (n_reg > GRID_MAX) return GRID_MAX;
    return n_reg;
  endfunction

  function automatic longint grid_at(int r, int c, int n);
    if (r < 0 || c < 0 || r >= n || c >= n) return 0;
    return grid[r*GRID_MAX + c];
  endfunction

  function automatic void solve_grid();
    int     n;
    int     lim;
    longint big, nv, ov, d;
    n   = eff_size();
    lim = (lim_reg == 0) ? 1 : lim_reg;
    foreach (grid[i]) grid[i] = 0;
    sweeps_m = 0;
    forever begin
      big = 0;
      for (int color = 0; color < 2; color++)
        for (int r = 0; r < n; r++)
          for (int c = 0; c < n; c++) begin
            if (((r + c) & 1) != color) continue;
            ov = grid[r*GRID_MAX + c];
            nv = (grid_at(r-1, c, n) + grid_at(r+1, c, n) + grid_at(r, c-1, n)
                  + grid_at(r, c+1, n) - step_reg) >>> 2;
            if (nv > 64'sh7FFF_FFFF) nv = 64'sh7FFF_FFFF;
            if (nv < -64'sh8000_0000) nv = -64'sh8000_0000;
            grid[r*GRID_MAX + c] = nv;
            d = (nv >= ov) ? nv - ov : ov - nv;
            if (d > 64'h7FFF_FFFF) d = 64'h7FFF_FFFF;
            if (d > big) big = d;
          end
      sweeps_m++;
      change_m = big;
      if (big <= tol_reg) begin
        conv_m = 1'b1;
        break;
      end
      if (sweeps_m >= lim) begin
        conv_m = 1'b0;
        break;
      end
    end
  endfunction

  task automatic issue(logic mode, int row, int col);
    cmd_item_t  ci;
    rsp_item_t  ri;
    int         n;
    logic [5:0] r6;
    logic [5:0] c6;
    r6 = 6'(row);
    c6 = 6'(col);
    ci = '{mode: mode, row: r6, col: c6};
    ri.cell_val = '0;
    if (mode == MODE_RUN) solve_grid();
    else begin
      n = eff_size();
      ri.cell_val = 32'(grid_at(int'(r6), int'(c6), n));
    end
    ri.sweeps = sweeps_m[15:0];
    ri.change = change_m[30:0];
    ri.conv   = conv_m;
    pending_cmds.insert(pending_cmds.size(), ci);
    expected_rsps.insert(expected_rsps.size(), ri);
  endtask

  task automatic settle();
    while (expected_rsps.size() != 0 || pending_cmds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= 31'(data);
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      REG_GRID_SIZE:  n_reg    = data & 32'h7F;
      REG_TOLERANCE:  tol_reg  = data & 32'h7FFF_FFFF;
      REG_STEP_SQ:    step_reg = data & 32'h1FF_FFFF;
      REG_ITER_LIMIT: lim_reg  = data & 32'hFFFF;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg.valid <= 1'b0;
  endtask

  task automatic setup(int unsigned g, int unsigned t, int unsigned s, int unsigned l);
    write_reg(REG_GRID_SIZE, g);
    write_reg(REG_TOLERANCE, t);
    write_reg(REG_STEP_SQ, s);
    write_reg(REG_ITER_LIMIT, l);
    end_writes();
  endtask

  task automatic random_phase(int count);
    int unsigned n;
    int unsigned t;
    n = $urandom_range(1, 6);
    case ($urandom_range(2))
      0: t = 0;
      1: t = $urandom_range(0, 5000);
      default: t = $urandom;
    endcase
    setup(($urandom & 32'h7FFF_FF80) | n, t, $urandom,
          ($urandom & 32'h7FFF_0000) | $urandom_range(0, 30));
    issue(MODE_RUN, $urandom, $urandom);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) issue(MODE_RUN, $urandom, $urandom);
      else if ($urandom_range(9) < 7)
        issue(MODE_READ, $urandom_range(0, n-1), $urandom_range(0, n-1));
      else issue(MODE_READ, $urandom, $urandom);
    end
    settle();
  endtask

  initial begin
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    cmd.valid = 1'b0;
    cmd.mode  = MODE_RUN;
    cmd.row   = '0;
    cmd.col   = '0;
    rsp.ready = 1'b0;
    foreach (grid[i]) grid[i] = 0;
    sweeps_m = 0;
    change_m = 0;
    conv_m   = 1'b0;
    n_reg    = 64;
    tol_reg  = 1678;
    step_reg = 3971;
    lim_reg  = 65535;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // nothing run yet
    issue(MODE_READ, 0, 0);
    issue(MODE_READ, 63, 63);
    settle();

    // strong source, never converges
    setup(4, 0, 32'h1FF_FFFF, 5);
    issue(MODE_RUN, 0, 0);
    issue(MODE_READ, 0, 0);
    issue(MODE_READ, 1, 2);
    issue(MODE_READ, 3, 3);
    issue(MODE_READ, 4, 0);
    settle();

    // size zero, limit zero, no source
    setup(0, 32'h7FFF_FFFF, 0, 0);
    issue(MODE_RUN, 0, 0);
    issue(MODE_READ, 0, 0);
    issue(MODE_READ, 0, 1);
    settle();

    // oversize grid, one sweep
    setup(127, 32'h7FFF_FFFF, 3971, 1);
    issue(MODE_RUN, 0, 0);
    issue(MODE_READ, 63, 63);
    issue(MODE_READ, 32, 17);
    settle();
    setup(64, 0, 32'h100_0000, 1);
    issue(MODE_RUN, 0, 0);
    issue(MODE_READ, 0, 63);
    settle();

    // shrink grid without a run
    write_reg(REG_GRID_SIZE, 3);
    end_writes();
    issue(MODE_READ, 2, 2);
    issue(MODE_READ, 5, 5);
    settle();

    setup(5, 1678, 3971, 65535);
    issue(MODE_RUN, 0, 0);
    issue(MODE_READ, 2, 2);
    issue(MODE_READ, 4, 1);
    settle();

    random_phase(20);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(20);
    send_idle_pct = 10;
    recv_idle_pct = 10;
    stall_req++;
    random_phase(20);
    random_phase(20);

    settle();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // command driver
  always @(posedge clk) begin
    if (rst) cmd.valid <= 1'b0;
    else if (!cmd.valid || cmd.ready) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd.mode  <= pending_cmds[0].mode;
        cmd.row   <= pending_cmds[0].row;
        cmd.col   <= pending_cmds[0].col;
        cmd.valid <= 1'b1;
        void'(pending_cmds.pop_front());
      end else cmd.valid <= 1'b0;
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      stall_left <= 400;
    end else if (stall_left > 0) stall_left <= stall_left - 1;
  end

  // result monitor
  always @(posedge clk) begin
    rsp_item_t want;
    if (rst) rsp.ready <= 1'b0;
    else begin
      rsp.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.cell_value !== want.cell_val) begin
            $error("cell_value: expected %h, got %h", want.cell_val, rsp.cell_value);
            errors++;
          end
          if (rsp.sweeps_done !== want.sweeps) begin
            $error("sweeps_done: expected %0d, got %0d", want.sweeps, rsp.sweeps_done);
            errors++;
          end
          if (rsp.final_change !== want.change) begin
            $error("final_change: expected %h, got %h", want.change, rsp.final_change);
            errors++;
          end
          if (rsp.converged !== want.conv) begin
            $error("converged: expected %b, got %b", want.conv, rsp.converged);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end
endmodule

// ===== filelist.f =====
src/rbgs_pkg.sv
src/rbgs_if.sv
src/rbgs_ram.sv
src/red_black_gauss_seidel_poisson.sv
test/rbgs_tb_if.sv
test/tb_red_black_gauss_seidel_poisson.sv
